// ===== design/sspaw_pkg.sv =====
// ----------------------------------------------------------------------------
// sspaw_pkg
// shared widths, codes, microcode program and fixed-point helpers of the
// state-space controller
// ----------------------------------------------------------------------------
package sspaw_pkg;

  localparam int COEFF_BITS  = 16;
  localparam int STATE_BITS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_FRAC  = COEFF_BITS - 3;
  localparam int RECIP_BITS  = 32;
  localparam int RECIP_FRAC  = 15;
  localparam int Y_BITS      = 48;
  localparam int LIMIT_BITS  = 15;
  localparam int ORDER_BITS  = 2;

  localparam int CFG_DATA_W  = 4 * COEFF_BITS;
  localparam int CFG_IDX_W   = 3;

  // operand of the shared multiplier is cut into a low and a high chunk
  localparam int OPND_W  = Y_BITS + 1;
  localparam int CHUNK_W = 24;
  localparam int HI_W    = OPND_W - CHUNK_W;
  localparam int MUL_W   = RECIP_BITS;
  localparam int PROD_W  = MUL_W + HI_W;
  localparam int ACC_W   = PROD_W + CHUNK_W + 1;

  localparam int PC_W = 5;

  localparam logic signed [ACC_W-1:0] Y_MAX_A =
    {{(ACC_W-Y_BITS+1){1'b0}}, {(Y_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN_A = ~Y_MAX_A;
  localparam logic signed [ACC_W-1:0] X_MAX_A =
    {{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] X_MIN_A = ~X_MAX_A;
  localparam logic signed [Y_BITS-1:0] DRV_MAX_Y =
    {{(Y_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [Y_BITS-1:0] DRV_MIN_Y = ~DRV_MAX_Y;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A, CFG_B, CFG_C, CFG_D, CFG_RECIP, CFG_LIMIT, CFG_ENABLE, CFG_ORDER
  } cfg_idx_e;

  typedef enum logic [3:0] {
    COEF_C0, COEF_C1, COEF_D, COEF_RECIP,
    COEF_A00, COEF_A01, COEF_A10, COEF_A11, COEF_B0, COEF_B1
  } coef_sel_e;

  typedef enum logic [1:0] {
    OPND_X0, OPND_X1, OPND_U, OPND_DIFF
  } opnd_sel_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_Y, OP_EMIT, OP_CORR, OP_UADJ, OP_X0N, OP_X1, OP_COMMIT
  } op_e;

  typedef enum logic [1:0] {
    J_NEXT, J_ALWAYS, J_PD, J_NO_CLAMP
  } jmp_e;

  typedef struct packed {
    logic en;
    logic clr;
    logic hi;
  } mac_ctl_t;

  typedef struct packed {
    mac_ctl_t        mac;
    coef_sel_e       coef;
    opnd_sel_e       opnd;
    op_e             op;
    jmp_e            jmp;
    logic [PC_W-1:0] tgt;
  } uword_t;

  localparam logic [PC_W-1:0] PC_LOAD    = PC_W'(0);
  localparam logic [PC_W-1:0] PC_Y_TAIL  = PC_W'(7);
  localparam logic [PC_W-1:0] PC_X0_UPD  = PC_W'(15);
  localparam logic [PC_W-1:0] PC_X0_TAIL = PC_W'(21);
  localparam logic [PC_W-1:0] PC_COMMIT  = PC_W'(31);

  function automatic uword_t mac_w(input coef_sel_e c, input opnd_sel_e o,
                                   input logic clr, input logic hi,
                                   input jmp_e j, input logic [PC_W-1:0] t);
    uword_t w;
    w.mac  = '{en: 1'b1, clr: clr, hi: hi};
    w.coef = c;
    w.opnd = o;
    w.op   = OP_NONE;
    w.jmp  = j;
    w.tgt  = t;
    return w;
  endfunction

  function automatic uword_t op_w(input op_e op, input jmp_e j,
                                  input logic [PC_W-1:0] t);
    uword_t w;
    w.mac  = '{en: 1'b0, clr: 1'b0, hi: 1'b0};
    w.coef = COEF_C0;
    w.opnd = OPND_X0;
    w.op   = op;
    w.jmp  = j;
    w.tgt  = t;
    return w;
  endfunction

  // control program, one word per step
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = op_w(OP_LOAD, J_NEXT, PC_LOAD);
      5'd1:    w = mac_w(COEF_C0, OPND_X0, 1'b1, 1'b0, J_NEXT, PC_LOAD);
      5'd2:    w = mac_w(COEF_C0, OPND_X0, 1'b0, 1'b1, J_NEXT, PC_LOAD);
      5'd3:    w = mac_w(COEF_D, OPND_U, 1'b0, 1'b0, J_NEXT, PC_LOAD);
      5'd4:    w = mac_w(COEF_D, OPND_U, 1'b0, 1'b1, J_PD, PC_Y_TAIL);
      5'd5:    w = mac_w(COEF_C1, OPND_X1, 1'b0, 1'b0, J_NEXT, PC_LOAD);
      5'd6:    w = mac_w(COEF_C1, OPND_X1, 1'b0, 1'b1, J_NEXT, PC_LOAD);
      5'd7:    w = op_w(OP_NONE, J_NEXT, PC_LOAD);
      5'd8:    w = op_w(OP_Y, J_NEXT, PC_LOAD);
      5'd9:    w = op_w(OP_EMIT, J_NO_CLAMP, PC_X0_UPD);
      5'd10:   w = mac_w(COEF_RECIP, OPND_DIFF, 1'b1, 1'b0, J_NEXT, PC_LOAD);
      5'd11:   w = mac_w(COEF_RECIP, OPND_DIFF, 1'b0, 1'b1, J_NEXT, PC_LOAD);
      5'd12:   w = op_w(OP_NONE, J_NEXT, PC_LOAD);
      5'd13:   w = op_w(OP_CORR, J_NEXT, PC_LOAD);
      5'd14:   w = op_w(OP_UADJ, J_NEXT, PC_LOAD);
      5'd15:   w = mac_w(COEF_A00, OPND_X0, 1'b1, 1'b0, J_NEXT, PC_LOAD);
      5'd16:   w = mac_w(COEF_A00, OPND_X0, 1'b0, 1'b1, J_NEXT, PC_LOAD);
      5'd17:   w = mac_w(COEF_B0, OPND_U, 1'b0, 1'b0, J_NEXT, PC_LOAD);
      5'd18:   w = mac_w(COEF_B0, OPND_U, 1'b0, 1'b1, J_PD, PC_X0_TAIL);
      5'd19:   w = mac_w(COEF_A01, OPND_X1, 1'b0, 1'b0, J_NEXT, PC_LOAD);
      5'd20:   w = mac_w(COEF_A01, OPND_X1, 1'b0, 1'b1, J_NEXT, PC_LOAD);
      5'd21:   w = op_w(OP_NONE, J_NEXT, PC_LOAD);
      5'd22:   w = op_w(OP_X0N, J_PD, PC_COMMIT);
      5'd23:   w = mac_w(COEF_A10, OPND_X0, 1'b1, 1'b0, J_NEXT, PC_LOAD);
      5'd24:   w = mac_w(COEF_A10, OPND_X0, 1'b0, 1'b1, J_NEXT, PC_LOAD);
      5'd25:   w = mac_w(COEF_A11, OPND_X1, 1'b0, 1'b0, J_NEXT, PC_LOAD);
      5'd26:   w = mac_w(COEF_A11, OPND_X1, 1'b0, 1'b1, J_NEXT, PC_LOAD);
      5'd27:   w = mac_w(COEF_B1, OPND_U, 1'b0, 1'b0, J_NEXT, PC_LOAD);
      5'd28:   w = mac_w(COEF_B1, OPND_U, 1'b0, 1'b1, J_NEXT, PC_LOAD);
      5'd29:   w = op_w(OP_NONE, J_NEXT, PC_LOAD);
      5'd30:   w = op_w(OP_X1, J_NEXT, PC_LOAD);
      5'd31:   w = op_w(OP_COMMIT, J_ALWAYS, PC_LOAD);
      default: w = op_w(OP_NONE, J_ALWAYS, PC_LOAD);
    endcase
    return w;
  endfunction

  function automatic logic signed [MUL_W-1:0] cext(input logic [COEFF_BITS-1:0] c);
    return {{(MUL_W-COEFF_BITS){c[COEFF_BITS-1]}}, c};
  endfunction

  // round half up, then arithmetic shift right
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] a,
                                                        input int unsigned s);
    logic signed [ACC_W-1:0] h;
    h = ACC_W'(1) << (s - 1);
    return (a + h) >>> s;
  endfunction

  function automatic logic signed [Y_BITS-1:0] sat_y(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    if (a > Y_MAX_A) begin
      r = Y_MAX_A;
    end else if (a < Y_MIN_A) begin
      r = Y_MIN_A;
    end else begin
      r = a;
    end
    return r[Y_BITS-1:0];
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_x(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    if (a > X_MAX_A) begin
      r = X_MAX_A;
    end else if (a < X_MIN_A) begin
      r = X_MIN_A;
    end else begin
      r = a;
    end
    return r[STATE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_drive(
      input logic signed [Y_BITS-1:0] y);
    logic signed [Y_BITS-1:0] r;
    if (y > DRV_MAX_Y) begin
      r = DRV_MAX_Y;
    end else if (y < DRV_MIN_Y) begin
      r = DRV_MIN_Y;
    end else begin
      r = y;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== design/sspaw_mac.sv =====
// ----------------------------------------------------------------------------
// sspaw_mac
// shared multiply-accumulate unit: registered product, then wide accumulate
// with an optional chunk shift
// ----------------------------------------------------------------------------
module sspaw_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sspaw_pkg::mac_ctl_t                ctl_i,
  input  logic signed [sspaw_pkg::MUL_W-1:0] coef_i,
  input  logic signed [sspaw_pkg::HI_W-1:0]  opnd_i,
  output logic signed [sspaw_pkg::ACC_W-1:0] acc_o
);
  import sspaw_pkg::*;

  mac_ctl_t                ctl_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= PROD_W'(coef_i * opnd_i);
    end
  end

  always_comb begin
    addend = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (ctl_q.hi) begin
      addend = addend <<< CHUNK_W;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q.en) begin
      acc_q <= ctl_q.clr ? addend : acc_q + addend;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== design/state_space_pid_antiwindup.sv =====
// ----------------------------------------------------------------------------
// state_space_pid_antiwindup
// fixed-point state-space PID/PD controller with back-calculation anti-windup
// ----------------------------------------------------------------------------
// One error sample per request yields one drive request. The output
// y = C.x + D.u comes from the old state, the new state x = A.x + B.u' is
// formed afterwards without aliasing; with anti-windup on, y is clamped to
// +-limit and u' = u - (y - clamp)/D uses the configured reciprocal of D.
// All products run through one 32x25 multiply-accumulate unit driven by a
// 32-step microcode program, each operand split into a 24-bit low chunk and
// a 25-bit high chunk; the PD form skips all steps of the second state,
// and a correction pass runs only when the clamp engages. The next sample is
// taken only when the program has returned to its first step; the drive
// request waits in an output register while the state update proceeds.
module state_space_pid_antiwindup (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sspaw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sspaw_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [sspaw_pkg::SAMPLE_BITS-1:0]      s_axis_tdata,  // error_sample
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [sspaw_pkg::SAMPLE_BITS-1:0]      m_axis_tdata,  // drive_value
  output logic                                   m_axis_tuser   // limited
);
  import sspaw_pkg::*;

  // configuration
  logic [CFG_DATA_W-1:0]        a_q;
  logic [2*COEFF_BITS-1:0]      b_q;
  logic [2*COEFF_BITS-1:0]      c_q;
  logic [COEFF_BITS-1:0]        d_q;
  logic [RECIP_BITS-1:0]        recip_q;
  logic [LIMIT_BITS-1:0]        limit_q;
  logic                         en_q;
  logic [ORDER_BITS-1:0]        order_q;

  // sequencer and datapath
  logic [PC_W-1:0]              pc_q, pc_d;
  uword_t                       uw;
  logic                         pd, stall, take;
  logic signed [STATE_BITS-1:0] x0_q, x1_q, x0n_q;
  logic signed [Y_BITS-1:0]     u_q, y_q;
  logic signed [OPND_W-1:0]     diff_q;
  logic signed [MUL_W-1:0]      coef;
  logic signed [OPND_W-1:0]     opnd_full;
  logic signed [HI_W-1:0]       opnd_chunk;
  mac_ctl_t                     mac_ctl;
  logic signed [ACC_W-1:0]      acc;

  // emit logic
  logic signed [Y_BITS-1:0]      lim_y, clampv;
  logic                          over, under, clamp;
  logic signed [SAMPLE_BITS-1:0] drive_sat;
  logic                          sat_flag;
  logic signed [OPND_W-1:0]      diff;
  logic signed [Y_BITS:0]        u_minus;
  logic                          emit;

  logic                          out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]        drive_q;
  logic                          limited_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      recip_q <= '0;
      limit_q <= '1;
      en_q    <= 1'b0;
      order_q <= ORDER_BITS'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_A:      a_q     <= cfg_wdata_i;
        CFG_B:      b_q     <= cfg_wdata_i[2*COEFF_BITS-1:0];
        CFG_C:      c_q     <= cfg_wdata_i[2*COEFF_BITS-1:0];
        CFG_D:      d_q     <= cfg_wdata_i[COEFF_BITS-1:0];
        CFG_RECIP:  recip_q <= cfg_wdata_i[RECIP_BITS-1:0];
        CFG_LIMIT:  limit_q <= cfg_wdata_i[LIMIT_BITS-1:0];
        CFG_ENABLE: en_q    <= cfg_wdata_i[0];
        CFG_ORDER:  order_q <= cfg_wdata_i[ORDER_BITS-1:0];
        default:    ;
      endcase
    end
  end

  assign uw = ucode(pc_q);
  assign pd = (order_q == ORDER_BITS'(1));

  always_comb begin
    unique case (uw.coef)
      COEF_C0:    coef = cext(c_q[0*COEFF_BITS +: COEFF_BITS]);
      COEF_C1:    coef = cext(c_q[1*COEFF_BITS +: COEFF_BITS]);
      COEF_D:     coef = cext(d_q);
      COEF_RECIP: coef = recip_q;
      COEF_A00:   coef = cext(a_q[0*COEFF_BITS +: COEFF_BITS]);
      COEF_A01:   coef = cext(a_q[1*COEFF_BITS +: COEFF_BITS]);
      COEF_A10:   coef = cext(a_q[2*COEFF_BITS +: COEFF_BITS]);
      COEF_A11:   coef = cext(a_q[3*COEFF_BITS +: COEFF_BITS]);
      COEF_B0:    coef = cext(b_q[0*COEFF_BITS +: COEFF_BITS]);
      COEF_B1:    coef = cext(b_q[1*COEFF_BITS +: COEFF_BITS]);
      default:    coef = '0;
    endcase
  end

  always_comb begin
    unique case (uw.opnd)
      OPND_X0:   opnd_full = {{(OPND_W-STATE_BITS){x0_q[STATE_BITS-1]}}, x0_q};
      OPND_X1:   opnd_full = {{(OPND_W-STATE_BITS){x1_q[STATE_BITS-1]}}, x1_q};
      OPND_U:    opnd_full = {{(OPND_W-Y_BITS){u_q[Y_BITS-1]}}, u_q};
      OPND_DIFF: opnd_full = diff_q;
      default:   opnd_full = '0;
    endcase
    if (uw.mac.hi) begin
      opnd_chunk = opnd_full[OPND_W-1:CHUNK_W];
    end else begin
      opnd_chunk = {{(HI_W-CHUNK_W){1'b0}}, opnd_full[CHUNK_W-1:0]};
    end
  end

  always_comb begin
    mac_ctl    = uw.mac;
    mac_ctl.en = uw.mac.en && !stall;
  end

  sspaw_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (coef),
    .opnd_i (opnd_chunk),
    .acc_o  (acc)
  );

  // clamp and saturation of the output sum
  always_comb begin
    lim_y     = {{(Y_BITS-LIMIT_BITS){1'b0}}, limit_q};
    over      = y_q > lim_y;
    under     = y_q < -lim_y;
    clamp     = en_q && (over || under);
    clampv    = over ? lim_y : -lim_y;
    diff      = {y_q[Y_BITS-1], y_q} - {clampv[Y_BITS-1], clampv};
    drive_sat = sat_drive(y_q);
    sat_flag  = (y_q != {{(Y_BITS-SAMPLE_BITS){drive_sat[SAMPLE_BITS-1]}}, drive_sat});
    u_minus   = {u_q[Y_BITS-1], u_q} - {y_q[Y_BITS-1], y_q};
  end

  // sequencer
  always_comb begin
    stall = ((uw.op == OP_LOAD) && !s_axis_tvalid) ||
            ((uw.op == OP_EMIT) && out_valid_q && !m_axis_tready);
    unique case (uw.jmp)
      J_NEXT:     take = 1'b0;
      J_ALWAYS:   take = 1'b1;
      J_PD:       take = pd;
      J_NO_CLAMP: take = !clamp;
      default:    take = 1'b0;
    endcase
    if (stall) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.tgt;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  assign emit = (uw.op == OP_EMIT) && !stall;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_LOAD;
      out_valid_q <= 1'b0;
      x0_q        <= '0;
      x1_q        <= '0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (uw.op == OP_X1) begin
        x1_q <= sat_x(rnd_shift(acc, COEFF_FRAC));
      end
      if (uw.op == OP_COMMIT) begin
        x0_q <= x0n_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_LOAD: begin
        if (s_axis_tvalid) begin
          u_q <= {{(Y_BITS-SAMPLE_BITS){s_axis_tdata[SAMPLE_BITS-1]}}, s_axis_tdata};
        end
      end
      OP_Y: begin
        y_q <= sat_y(rnd_shift(acc, COEFF_FRAC));
      end
      OP_EMIT: begin
        if (!stall) begin
          diff_q    <= diff;
          drive_q   <= clamp ? clampv[SAMPLE_BITS-1:0] : drive_sat;
          limited_q <= clamp || sat_flag;
        end
      end
      OP_CORR: begin
        y_q <= sat_y(rnd_shift(acc, RECIP_FRAC));
      end
      OP_UADJ: begin
        u_q <= sat_y({{(ACC_W-Y_BITS-1){u_minus[Y_BITS]}}, u_minus});
      end
      OP_X0N: begin
        x0n_q <= sat_x(rnd_shift(acc, COEFF_FRAC));
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (uw.op == OP_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drive_q;
  assign m_axis_tuser  = limited_q;

`ifndef ASSERT_OFF
  a_acc_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_Y || uw.op == OP_CORR || uw.op == OP_X0N || uw.op == OP_X1)
      |-> !$past(mac_ctl.en))
    else $error("accumulator read while a product is still in flight");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> pc_q == PC_LOAD + PC_W'(1))
    else $error("accepted sample did not start the program");

  a_clamp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && en_q && !m_axis_tuser
      |-> (signed'(m_axis_tdata) <= signed'({1'b0, limit_q})) &&
          (signed'(m_axis_tdata) >= -signed'({1'b0, limit_q})))
    else $error("unflagged drive beyond the clamp limit");
`endif

endmodule
